// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/i2cm_pkg.sv =====
package i2cm_pkg;

    // Command codes.
    localparam logic [2:0] OP_START     = 3'd0;
    localparam logic [2:0] OP_STOP      = 3'd1;
    localparam logic [2:0] OP_WRITE     = 3'd2;
    localparam logic [2:0] OP_READ      = 3'd3;
    localparam logic [2:0] OP_REG_WRITE = 3'd4;
    localparam logic [2:0] OP_REG_READ  = 3'd5;

    // Segment codes: each command is a list of these.
    localparam logic [3:0] SEG_NONE         = 4'd0;
    localparam logic [3:0] SEG_START        = 4'd1;
    localparam logic [3:0] SEG_STOP         = 4'd2;
    localparam logic [3:0] SEG_WR_VALUE     = 4'd3;
    localparam logic [3:0] SEG_WR_DEVICE    = 4'd4;
    localparam logic [3:0] SEG_WR_REGISTER  = 4'd5;
    localparam logic [3:0] SEG_WR_DEVICE_RD = 4'd6;
    localparam logic [3:0] SEG_RD_HELD      = 4'd7;
    localparam logic [3:0] SEG_RD_NACK      = 4'd8;

    // Start and stop phase tables, entry i at bit i. Pin 0 is SCL, pin 1 is SDA.
    localparam logic [5:0] START_PIN = 6'b101010;
    localparam logic [5:0] START_LVL = 6'b100111;
    localparam logic [5:0] STOP_PIN  = 6'b101010;
    localparam logic [5:0] STOP_LVL  = 6'b110100;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd250;

    localparam logic [7:0] RD_FLAG = 8'h01;

    // Phase number modulo three within the data bits of a byte write.
    localparam logic [1:0] MOD3 [32] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
        2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
        2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
    };

    typedef struct packed {
        logic        busy;
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [4:0]  off;
        logic [15:0] tick;
        logic [7:0]  shift;
        logic        scl;
        logic        sda;
        logic [7:0]  rx;
        logic        ack;
        logic        hack;
        logic [7:0]  hdev;
        logic [7:0]  hreg;
        logic [7:0]  hval;
    } t_state;

    localparam t_state STATE_RESET = '{
        busy: 1'b0, op: OP_START, slot: 3'd0, off: 5'd0, tick: 16'd0,
        shift: 8'd0, scl: 1'b1, sda: 1'b1, rx: 8'd0, ack: 1'b0,
        hack: 1'b0, hdev: 8'd0, hreg: 8'd0, hval: 8'd0
    };

    function automatic logic [3:0] seg_code(input logic [2:0] op, input logic [2:0] slot);
        logic [3:0] c;
        c = SEG_NONE;
        case (op)
            OP_START:  c = (slot == 3'd0) ? SEG_START : SEG_NONE;
            OP_STOP:   c = (slot == 3'd0) ? SEG_STOP : SEG_NONE;
            OP_WRITE:  c = (slot == 3'd0) ? SEG_WR_VALUE : SEG_NONE;
            OP_READ:   c = (slot == 3'd0) ? SEG_RD_HELD : SEG_NONE;
            OP_REG_WRITE: begin
                case (slot)
                    3'd0:    c = SEG_START;
                    3'd1:    c = SEG_WR_DEVICE;
                    3'd2:    c = SEG_WR_REGISTER;
                    3'd3:    c = SEG_WR_VALUE;
                    3'd4:    c = SEG_STOP;
                    default: c = SEG_NONE;
                endcase
            end
            OP_REG_READ: begin
                case (slot)
                    3'd0:    c = SEG_START;
                    3'd1:    c = SEG_WR_DEVICE;
                    3'd2:    c = SEG_WR_REGISTER;
                    3'd3:    c = SEG_START;
                    3'd4:    c = SEG_WR_DEVICE_RD;
                    3'd5:    c = SEG_RD_NACK;
                    3'd6:    c = SEG_STOP;
                    default: c = SEG_NONE;
                endcase
            end
            default: c = SEG_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] seg_count(input logic [2:0] op);
        logic [2:0] n;
        case (op)
            OP_REG_WRITE: n = 3'd5;
            OP_REG_READ:  n = 3'd7;
            OP_START, OP_STOP, OP_WRITE, OP_READ: n = 3'd1;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] seg_len(input logic [3:0] code, input logic hack);
        logic [4:0] n;
        case (code)
            SEG_START, SEG_STOP: n = 5'd6;
            SEG_WR_VALUE, SEG_WR_DEVICE, SEG_WR_REGISTER, SEG_WR_DEVICE_RD: n = 5'd28;
            SEG_RD_HELD: n = 5'd20 + {4'd0, hack};
            SEG_RD_NACK: n = 5'd20;
            default:     n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/i2cm_step.sv =====
// One item of work on the engine state: command launch or one tick.
module i2cm_step (
    input  i2cm_pkg::t_state i_state,
    input  logic             i_kind,
    input  logic [2:0]       i_op,
    input  logic [7:0]       i_data_byte,
    input  logic [7:0]       i_device_addr,
    input  logic [7:0]       i_reg_addr,
    input  logic             i_send_ack,
    input  logic             i_sda_in,
    input  logic [15:0]      i_phase_ticks,
    output i2cm_pkg::t_state o_state,
    output logic             o_done,
    output logic             o_accepted
);

    function automatic logic [7:0] seg_byte(input i2cm_pkg::t_state s, input logic [3:0] code);
        logic [7:0] b;
        case (code)
            i2cm_pkg::SEG_WR_DEVICE:    b = s.hdev;
            i2cm_pkg::SEG_WR_REGISTER:  b = s.hreg;
            i2cm_pkg::SEG_WR_DEVICE_RD: b = s.hdev | i2cm_pkg::RD_FLAG;
            default:                    b = s.hval;
        endcase
        return b;
    endfunction

    function automatic logic is_write(input logic [3:0] code);
        return (code == i2cm_pkg::SEG_WR_VALUE) || (code == i2cm_pkg::SEG_WR_DEVICE) ||
               (code == i2cm_pkg::SEG_WR_REGISTER) || (code == i2cm_pkg::SEG_WR_DEVICE_RD);
    endfunction

    // Pin setting at the start of a phase.
    function automatic i2cm_pkg::t_state enter_phase(input i2cm_pkg::t_state s,
                                                      input logic [3:0] code,
                                                      input logic [4:0] off);
        i2cm_pkg::t_state r;
        logic [2:0]       idx;
        logic             ack_slot;
        r        = s;
        idx      = off[2:0];
        ack_slot = (code == i2cm_pkg::SEG_RD_HELD) && s.hack;
        if (code == i2cm_pkg::SEG_START) begin
            if (i2cm_pkg::START_PIN[idx]) r.sda = i2cm_pkg::START_LVL[idx];
            else                          r.scl = i2cm_pkg::START_LVL[idx];
        end else if (code == i2cm_pkg::SEG_STOP) begin
            if (i2cm_pkg::STOP_PIN[idx]) r.sda = i2cm_pkg::STOP_LVL[idx];
            else                         r.scl = i2cm_pkg::STOP_LVL[idx];
        end else if (is_write(code)) begin
            if (off < 5'd24) begin
                case (i2cm_pkg::MOD3[off])
                    2'd0: begin
                        if (off == 5'd0) r.shift = seg_byte(s, code);
                        r.scl = 1'b0;
                    end
                    2'd1: begin
                        r.sda   = s.shift[7];
                        r.shift = {s.shift[6:0], 1'b0};
                    end
                    default: r.scl = 1'b1;
                endcase
            end else if (off == 5'd24) begin
                r.scl = 1'b0;
            end else if (off == 5'd25) begin
                r.sda = 1'b1;
            end else if (off == 5'd26) begin
                r.scl = 1'b1;
            end else begin
                r.scl = 1'b0;
            end
        end else begin
            // Byte read: release SDA, then eight SCL high/low pairs, then the ACK slot.
            if (off == 5'd0) begin
                r.shift = 8'd0;
                r.scl   = 1'b0;
            end else if (off == 5'd1) begin
                r.sda = 1'b1;
            end else if (off < 5'd18) begin
                r.scl = ~off[0];
            end else if (ack_slot) begin
                if (off == 5'd18) r.sda = 1'b0;
                else              r.scl = (off == 5'd19);
            end else begin
                r.scl = (off == 5'd18);
            end
        end
        return r;
    endfunction

    // Sampling at the end of a phase.
    function automatic i2cm_pkg::t_state end_phase(input i2cm_pkg::t_state s,
                                                    input logic [3:0] code,
                                                    input logic [4:0] off,
                                                    input logic sda);
        i2cm_pkg::t_state r;
        r = s;
        if (is_write(code)) begin
            if (off == 5'd26) r.ack = ~sda;
        end else if ((code == i2cm_pkg::SEG_RD_HELD) || (code == i2cm_pkg::SEG_RD_NACK)) begin
            if ((off >= 5'd2) && (off < 5'd18) && !off[0]) begin
                r.shift = {s.shift[6:0], sda};
                if (off == 5'd16) r.rx = {s.shift[6:0], sda};
            end
        end
        return r;
    endfunction

    i2cm_pkg::t_state s;
    logic [3:0]       code;
    logic [15:0]      limit;
    logic [15:0]      tick_n;
    logic [4:0]       off_n;
    logic [2:0]       slot_n;

    always_comb begin
        s          = i_state;
        code       = i2cm_pkg::SEG_NONE;
        limit      = (i_phase_ticks == 16'd0) ? 16'd1 : i_phase_ticks;
        tick_n     = i_state.tick + 16'd1;
        off_n      = 5'd0;
        slot_n     = 3'd0;
        o_done     = 1'b0;
        o_accepted = 1'b0;
        if (!i_kind) begin
            if (!s.busy && (i_op <= i2cm_pkg::OP_REG_READ)) begin
                s.hval     = i_data_byte;
                s.hdev     = i_device_addr;
                s.hreg     = i_reg_addr;
                s.hack     = i_send_ack;
                s.op       = i_op;
                s.slot     = 3'd0;
                s.off      = 5'd0;
                s.tick     = 16'd0;
                s.busy     = 1'b1;
                s          = enter_phase(s, i2cm_pkg::seg_code(i_op, 3'd0), 5'd0);
                o_accepted = 1'b1;
            end
        end else if (s.busy) begin
            s.tick = tick_n;
            if (tick_n >= limit) begin
                code   = i2cm_pkg::seg_code(s.op, s.slot);
                s      = end_phase(s, code, s.off, i_sda_in);
                s.tick = 16'd0;
                if ((s.off + 5'd1) == i2cm_pkg::seg_len(code, s.hack)) begin
                    slot_n = s.slot + 3'd1;
                    off_n  = 5'd0;
                end else begin
                    slot_n = s.slot;
                    off_n  = s.off + 5'd1;
                end
                s.slot = slot_n;
                s.off  = off_n;
                if (slot_n == i2cm_pkg::seg_count(s.op)) begin
                    s.busy = 1'b0;
                    o_done = 1'b1;
                end else begin
                    s = enter_phase(s, i2cm_pkg::seg_code(s.op, slot_n), off_n);
                end
            end
        end
        o_state = s;
    end

endmodule

// ===== hdl/i2c_master_byte_engine.sv =====
// Channel  | dir | handshake                      | payload
// ---------+-----+--------------------------------+--------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready  | tuser: kind; tdata: op, data_byte,
//          |     |                                | device_addr, reg_addr, send_ack, sda_in
// m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata: scl_level ... ack_ok
// cfg      | in  | i_cfg_we                       | i_cfg_wdata: phase_ticks
//
// One item is taken every clock cycle while the result side keeps up; each item gives
// exactly one result item, held in the result register once the item has passed from the
// input register through the step logic into the state and result registers.
// Reset is synchronous and active low; it sets SCL and SDA released and phase_ticks to 250.
// A stall on the result side holds the result register; the input register then fills
// and s_axis_tready drops until the result is taken.
module i2c_master_byte_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] op, [10:3] data_byte, [18:11] device_addr, [26:19] reg_addr,
    // [27] send_ack, [28] sda_in, [31:29] zero
    input  logic [31:0] s_axis_tdata,
    // [0] kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_level, [1] sda_release, [2] busy_res, [3] done_res, [4] accepted,
    // [12:5] read_data, [13] ack_ok, [15:14] zero
    output logic [15:0] m_axis_tdata
);

    // Input register: holds one item until the step logic can retire it.
    logic        r_in_valid;
    logic        r_in_kind;
    logic [31:0] r_in_data;

    // Engine state and the programmed phase length.
    i2cm_pkg::t_state r_state;
    i2cm_pkg::t_state n_state;
    logic [15:0]      r_phase_ticks;

    // Result register.
    logic        r_m_valid;
    logic [15:0] r_m_data;

    logic n_done;
    logic n_accepted;
    logic advance;

    // The stored item is processed whenever the result register is free or being emptied.
    assign advance       = r_in_valid && (!r_m_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cm_pkg::PHASE_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    i2cm_step u_step (
        .i_state       (r_state),
        .i_kind        (r_in_kind),
        .i_op          (r_in_data[2:0]),
        .i_data_byte   (r_in_data[10:3]),
        .i_device_addr (r_in_data[18:11]),
        .i_reg_addr    (r_in_data[26:19]),
        .i_send_ack    (r_in_data[27]),
        .i_sda_in      (r_in_data[28]),
        .i_phase_ticks (r_phase_ticks),
        .o_state       (n_state),
        .o_done        (n_done),
        .o_accepted    (n_accepted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2cm_pkg::STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // The result reports the levels and flags after this item's work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (advance) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (advance) begin
            r_m_data <= {2'b00, n_state.ack, n_state.rx, n_accepted, n_done,
                         n_state.busy, n_state.sda, n_state.scl};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ===== hdl/i2cm_checker.sv =====
`include "assert_macros.svh"

module i2cm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A stalled result stays put.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // With the result side open the input side never blocks.
    `ASSERT_IMPL(a_in_ready, i_clk, i_rst_n, m_axis_tready, s_axis_tready, "input blocked while output ready")

    // A finished command leaves the engine idle and was not a new command.
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[3], !m_axis_tdata[2] && !m_axis_tdata[4], "done with engine still busy")

    // A taken command always starts a busy sequence.
    `ASSERT_IMPL(a_acc_busy, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[4], m_axis_tdata[2], "accepted command without busy")

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);
